[sv/kmpnth_pkg.sv]
`default_nettype none

package kmpnth_pkg;

    // Result codes carried on the response channel
    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_STORED    = 3'd3,
        ST_ERROR     = 3'd4
    } t_status;

    // Request command codes
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OCC_W  = 16;
    localparam int unsigned POS_W  = 16;

    // Per-cell control: load a pattern byte, or step the match bit on a text byte
    typedef struct packed {
        logic              load;
        logic              step;
        logic [BYTE_W-1:0] data;
    } t_cell_ctl;

endpackage

`default_nettype wire

[sv/kmpnth_req_if.sv]
`default_nettype none

interface kmpnth_req_if import kmpnth_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic              first;
    logic              last;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, command, first, last, data_byte, input ready);
    modport sink   (input valid, command, first, last, data_byte, output ready);
endinterface

`default_nettype wire

[sv/kmpnth_rsp_if.sv]
`default_nettype none

interface kmpnth_rsp_if import kmpnth_pkg::*; ();
    logic             valid;
    logic             ready;
    t_status          status;
    logic [POS_W-1:0] position;

    modport source (output valid, status, position, input ready);
    modport sink   (input valid, status, position, output ready);
endinterface

`default_nettype wire

[sv/kmpnth_cell.sv]
`default_nettype none

// One pattern position: holds its pattern byte and whether the text seen so far
// ends in a match of the pattern prefix up to and including this position.
module kmpnth_cell import kmpnth_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_match,
    output logic           o_match
);

    logic [BYTE_W-1:0] r_pat;
    logic              r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pat <= i_ctl.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.step) begin
            r_match <= i_match && (i_ctl.data == r_pat);
        end
    end

    assign o_match = r_match;

endmodule

`default_nettype wire

[sv/kmp_nth_occurrence_search_unit.sv]
`default_nettype none

// Pattern search unit reporting the n-th (possibly overlapping) occurrence of a
// byte pattern in a byte stream, with the answers of Knuth-Morris-Pratt search.
// Send pattern bytes (command 0, first on the opening byte) and then text bytes
// (command 1, first on the opening byte, last on the closing one); every request
// gives exactly one response. Pattern bytes answer "stored" or "error" (pattern
// longer than MAX_PATTERN). Text bytes answer "no result yet", "found" with the
// start position of the wanted occurrence, "not found" on the last byte, or
// "error" (no valid pattern, or text longer than MAX_TEXT). After a find or an
// error, text is ignored until a byte with first set. Any pattern byte ends a
// running search. The user writes the occurrence number to report (default 1)
// on the cfg port only while the unit is idle; the unit does not enforce this.
// Each request is taken, stepping the row of MAX_PATTERN match cells (one per
// pattern byte, each passing its match bit to its neighbour), then resolved: the
// tap at the pattern length is picked, the occurrence counted and the response
// register loaded. A waiting response does not stop the next request being taken;
// only a second finished response with the first still untaken holds the unit.
module kmp_nth_occurrence_search_unit import kmpnth_pkg::*; #(
    parameter int unsigned MAX_PATTERN = 64,
    parameter int unsigned MAX_TEXT    = 65536
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [OCC_W-1:0]  i_cfg_wr_data,
    kmpnth_req_if.sink             i_req,
    kmpnth_rsp_if.source           o_rsp
);

    localparam int unsigned CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int unsigned TXT_W = $clog2(MAX_TEXT + 1);
    localparam int unsigned DIF_W = (TXT_W > POS_W) ? TXT_W : POS_W;

    typedef enum logic {
        PH_TAKE,
        PH_RESOLVE
    } t_phase;

    t_phase            r_phase;
    logic [OCC_W-1:0]  r_wanted;
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic [TXT_W-1:0]  r_ti;
    logic [OCC_W-1:0]  r_occ;
    logic              r_fin;
    t_status           r_pend_status;
    logic              r_pend_search;
    logic              r_pend_last;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [POS_W-1:0]  r_out_pos;

    logic              take;
    logic [CNT_W-1:0]  eff_count;
    logic              eff_ovf;
    logic              pat_full;
    logic              eff_fin;
    logic [TXT_W-1:0]  eff_ti;
    logic              txt_err;
    logic              load_en;
    logic              step_en;
    logic              clear;
    logic [MAX_PATTERN-1:0] match_vec;
    logic [MAX_PATTERN-1:0] chain_in;
    t_cell_ctl         cell_ctl [MAX_PATTERN];

    logic [CNT_W-1:0]  cm1;
    logic              hit;
    logic [OCC_W-1:0]  occ_inc;
    logic [DIF_W-1:0]  pos_diff;
    logic              out_free;
    logic              resolve_en;

    // ---- request side: classify the request against the held state ----
    assign take      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_phase == PH_TAKE);

    // A first mark restarts the pattern or the text before this byte is handled
    assign eff_count = i_req.first ? '0 : r_count;
    assign eff_ovf   = i_req.first ? 1'b0 : r_ovf;
    assign pat_full  = eff_ovf || (eff_count >= CNT_W'(MAX_PATTERN));
    assign eff_fin   = i_req.first ? 1'b0 : r_fin;
    assign eff_ti    = i_req.first ? '0 : r_ti;
    assign txt_err   = (r_count == '0) || r_ovf || (eff_ti >= TXT_W'(MAX_TEXT));

    assign load_en = take && (i_req.command == CMD_PATTERN) && !pat_full;
    assign step_en = take && (i_req.command == CMD_TEXT) && !eff_fin && !txt_err;
    assign clear   = i_req.first;

    // ---- the cell row ----
    // Cell 0 always has an empty prefix behind it; the others take the
    // neighbour's match bit, dropped when a new text starts.
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign chain_in[k] = 1'b1;
        end else begin : g_body
            assign chain_in[k] = !clear && match_vec[k-1];
        end

        assign cell_ctl[k] = '{
            load: load_en && (eff_count == CNT_W'(k)),
            step: step_en,
            data: i_req.data_byte
        };

        kmpnth_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl[k]),
            .i_match (chain_in[k]),
            .o_match (match_vec[k])
        );
    end

    // ---- resolve side: tap at the pattern length, count, form the response ----
    assign cm1      = r_count - CNT_W'(1);
    assign hit      = match_vec[cm1[IDX_W-1:0]];
    assign occ_inc  = (r_occ != {OCC_W{1'b1}}) ? (r_occ + OCC_W'(1)) : r_occ;
    // r_ti already advanced past this byte, so this is the start index
    assign pos_diff = DIF_W'(r_ti) - DIF_W'(r_count);
    assign out_free = !r_out_valid || o_rsp.ready;
    assign resolve_en = (r_phase == PH_RESOLVE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TAKE;
            r_wanted      <= OCC_W'(1);
            r_count       <= '0;
            r_ovf         <= 1'b0;
            r_ti          <= '0;
            r_occ         <= '0;
            r_fin         <= 1'b0;
            r_pend_search <= 1'b0;
            r_pend_last   <= 1'b0;
            r_pend_status <= ST_NONE;
            r_out_valid   <= 1'b0;
            r_out_status  <= ST_NONE;
            r_out_pos     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_wanted <= i_cfg_wr_data;
            end

            // Raise the response when one is formed; drop it once the sink has taken it
            if (resolve_en) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_phase)
                PH_TAKE: begin
                    if (take) begin
                        r_phase       <= PH_RESOLVE;
                        r_pend_last   <= i_req.last;
                        if (i_req.command == CMD_PATTERN) begin
                            r_pend_search <= 1'b0;
                            r_fin         <= 1'b1;
                            if (pat_full) begin
                                r_ovf         <= 1'b1;
                                r_count       <= eff_count;
                                r_pend_status <= ST_ERROR;
                            end else begin
                                r_ovf         <= 1'b0;
                                r_count       <= eff_count + CNT_W'(1);
                                r_pend_status <= ST_STORED;
                            end
                        end else begin
                            if (i_req.first) begin
                                r_occ <= '0;
                            end
                            if (eff_fin) begin
                                r_pend_status <= ST_NONE;
                                r_pend_search <= 1'b0;
                            end else if (txt_err) begin
                                r_pend_status <= ST_ERROR;
                                r_pend_search <= 1'b0;
                                r_ti          <= eff_ti;
                                r_fin         <= 1'b1;
                            end else begin
                                r_pend_status <= ST_NONE;
                                r_pend_search <= 1'b1;
                                r_ti          <= eff_ti + TXT_W'(1);
                                r_fin         <= 1'b0;
                            end
                        end
                    end
                end
                PH_RESOLVE: begin
                    // Hold here until the output register is free
                    if (resolve_en) begin
                        r_phase <= PH_TAKE;
                        if (!r_pend_search) begin
                            r_out_status <= r_pend_status;
                            r_out_pos    <= '0;
                        end else if (hit && (occ_inc == r_wanted)) begin
                            r_occ        <= occ_inc;
                            r_out_status <= ST_FOUND;
                            r_out_pos    <= pos_diff[POS_W-1:0];
                            r_fin        <= 1'b1;
                        end else begin
                            if (hit) begin
                                r_occ <= occ_inc;
                            end
                            r_out_pos <= '0;
                            if (r_pend_last) begin
                                r_out_status <= ST_NOT_FOUND;
                                r_fin        <= 1'b1;
                            end else begin
                                r_out_status <= ST_NONE;
                            end
                        end
                    end
                end
                default: begin
                    r_phase <= PH_TAKE;
                end
            endcase
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.position = r_out_pos;

endmodule

`default_nettype wire
